@@ sv/vwbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwbp_pkg
// Shared types and constants of the variable-width bit packer.
// ----------------------------------------------------------------------------
package vwbp_pkg;

  localparam int unsigned WORD_BITS        = 32;
  localparam int unsigned WORD_BYTES       = 4;
  localparam int unsigned FBITS_W          = 6;
  localparam int unsigned COUNT_W          = 23;
  localparam longint unsigned MAX_STREAM_WORDS = 1048576;

  localparam longint unsigned COUNT_MAX_RAW = (longint'(1) << COUNT_W) - 1;
  localparam longint unsigned LIMIT_RAW     = MAX_STREAM_WORDS * WORD_BYTES;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT =
      COUNT_W'((LIMIT_RAW > COUNT_MAX_RAW) ? COUNT_MAX_RAW : LIMIT_RAW);

  localparam logic [FBITS_W-1:0] FULL_FREE  = FBITS_W'(WORD_BITS);
  localparam logic [COUNT_W:0]   WORD_INCR  = (COUNT_W+1)'(WORD_BYTES);

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_ALIGN = 2'd1,
    REQ_CLOSE = 2'd2
  } req_type_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [31:0]        field_value;
    logic [FBITS_W-1:0] field_bits;
  } item_t;

  typedef struct packed {
    logic [31:0]        packed_word;
    logic               word_valid;
    logic [COUNT_W-1:0] bytes_total;
    logic               stream_end;
  } result_t;

  // handshake between the input register and the packing stage
  typedef struct packed {
    logic   valid;
    item_t  item;
  } stage_req_t;

endpackage

@@ sv/vwbp_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwbp_in_if
// Request channel of the bit packer: valid/ready plus one request.
// ----------------------------------------------------------------------------
interface vwbp_in_if;
  import vwbp_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [31:0]        field_value;
  logic [FBITS_W-1:0] field_bits;

  modport source (output valid, output req_type, output field_value,
                  output field_bits, input ready);
  modport sink   (input valid, input req_type, input field_value,
                  input field_bits, output ready);
endinterface

@@ sv/vwbp_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwbp_out_if
// Result channel of the bit packer: valid/ready plus one result.
// ----------------------------------------------------------------------------
interface vwbp_out_if;
  import vwbp_pkg::*;

  logic               valid;
  logic               ready;
  logic [31:0]        packed_word;
  logic               word_valid;
  logic [COUNT_W-1:0] bytes_total;
  logic               stream_end;

  modport source (output valid, output packed_word, output word_valid,
                  output bytes_total, output stream_end, input ready);
  modport sink   (input valid, input packed_word, input word_valid,
                  input bytes_total, input stream_end, output ready);
endinterface

@@ sv/vwbp_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwbp_in_stage
// Input register: holds one request until the packing stage takes it.
// ----------------------------------------------------------------------------
module vwbp_in_stage
  import vwbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  vwbp_in_if.sink    in_chan,
  input  logic       take,
  output stage_req_t stage
);

  logic  valid_r;
  item_t item_r;
  logic  in_ready;

  assign in_ready      = !valid_r || take;
  assign in_chan.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      item_r.req_type    <= in_chan.req_type;
      item_r.field_value <= in_chan.field_value;
      item_r.field_bits  <= in_chan.field_bits;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

@@ sv/vwbp_pack_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwbp_pack_unit
// Packing state (holder, free count, byte count) and the single-pass update
// for one request.
// ----------------------------------------------------------------------------
module vwbp_pack_unit
  import vwbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  stage_req_t stage,
  input  logic       out_free,
  output logic       take,
  output logic       res_valid,
  output result_t    res
);

  logic [31:0]        holder_r, holder_nxt;
  logic [FBITS_W-1:0] free_r, free_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;

  logic [FBITS_W-1:0] free_cur;
  logic [FBITS_W-1:0] nbits;
  logic [FBITS_W-1:0] used;
  logic [FBITS_W-1:0] take_bits;
  logic [FBITS_W-1:0] free_after;
  logic [31:0]        val_m;
  logic [31:0]        take_mask;
  logic [31:0]        merged;
  logic [COUNT_W:0]   cnt_sum;
  logic [COUNT_W-1:0] cnt_inc;
  logic               produce;

  always_comb begin
    // an out-of-range free count means an empty holder
    free_cur = (free_r == '0 || free_r > FULL_FREE) ? FULL_FREE : free_r;
    nbits    = (stage.item.field_bits > FULL_FREE) ? FULL_FREE : stage.item.field_bits;
    used     = FULL_FREE - free_cur;
    take_bits  = (nbits < free_cur) ? nbits : free_cur;
    free_after = free_cur - take_bits;
    val_m      = stage.item.field_value & ~(32'((33'h1FFFFFFFF) << nbits));
    take_mask  = ~(32'((33'h1FFFFFFFF) << take_bits));
    merged     = holder_r | 32'((val_m & take_mask) << used);

    cnt_sum = {1'b0, cnt_r} + WORD_INCR;
    cnt_inc = (cnt_sum > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : cnt_sum[COUNT_W-1:0];

    holder_nxt = holder_r;
    free_nxt   = free_cur;
    cnt_nxt    = cnt_r;
    produce    = 1'b0;
    res.packed_word = '0;
    res.word_valid  = 1'b0;
    res.bytes_total = cnt_r;
    res.stream_end  = 1'b0;

    unique case (stage.item.req_type)
      REQ_WRITE: begin
        if (nbits != '0) begin
          if (free_after == '0) begin
            produce         = 1'b1;
            res.packed_word = merged;
            res.word_valid  = 1'b1;
            res.bytes_total = cnt_inc;
            cnt_nxt         = cnt_inc;
            // leftover high bits start the next word
            holder_nxt      = val_m >> take_bits;
            free_nxt        = FULL_FREE - (nbits - take_bits);
          end else begin
            holder_nxt = merged;
            free_nxt   = free_after;
          end
        end
      end
      REQ_ALIGN: begin
        if (free_cur < FULL_FREE) begin
          produce         = 1'b1;
          res.packed_word = holder_r;
          res.word_valid  = 1'b1;
          res.bytes_total = cnt_inc;
          cnt_nxt         = cnt_inc;
          holder_nxt      = '0;
          free_nxt        = FULL_FREE;
        end
      end
      REQ_CLOSE: begin
        produce = 1'b1;
        res.stream_end = 1'b1;
        if (free_cur < FULL_FREE) begin
          res.packed_word = holder_r;
          res.word_valid  = 1'b1;
          res.bytes_total = cnt_inc;
        end
        holder_nxt = '0;
        free_nxt   = FULL_FREE;
        cnt_nxt    = '0;
      end
      default: begin
      end
    endcase

    // requests without a result never wait for the output register
    take      = stage.valid && (!produce || out_free);
    res_valid = take && produce;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holder_r <= '0;
      free_r   <= FULL_FREE;
      cnt_r    <= '0;
    end else if (take) begin
      holder_r <= holder_nxt;
      free_r   <= free_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_r != '0 && free_r <= FULL_FREE)
    else $error("free bit count out of range");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && stage.item.req_type == REQ_CLOSE |=> cnt_r == '0 && free_r == FULL_FREE
      && holder_r == '0)
    else $error("state not cleared after close");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= COUNT_LIMIT)
    else $error("byte count above limit");

  a_cnt_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    take && stage.item.req_type != REQ_CLOSE |=> cnt_r >= $past(cnt_r))
    else $error("byte count went backwards within a stream");

endmodule

@@ sv/vwbp_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwbp_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module vwbp_out_stage
  import vwbp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     res_valid,
  input  result_t  res,
  output logic     out_free,
  vwbp_out_if.source out_chan
);

  logic    valid_r;
  result_t res_r;

  assign out_free = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      res_r <= res;
    end
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.packed_word = res_r.packed_word;
  assign out_chan.word_valid  = res_r.word_valid;
  assign out_chan.bytes_total = res_r.bytes_total;
  assign out_chan.stream_end  = res_r.stream_end;

endmodule

@@ sv/variable_width_bit_packer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_width_bit_packer_core
// LSB-first packer of 0..32-bit fields into 32-bit words.
//
// in_chan carries requests: write (append the low field_bits of field_value),
// align (flush a partly filled word) and close (flush, report the final byte
// count, mark stream_end, restart empty). Unknown request codes are dropped.
// out_chan carries at most one result per request, with the running byte
// count in bytes_total (saturating).
// Throughput: one request per cycle while the receiver keeps up. Path: the
// accepting edge loads the input register, the single-pass packing logic
// then fills the result register, and out_chan shows the result from there
// until the receiver takes it.
// Reset clears the holder, free count and byte count; both registers empty.
// When the receiver stalls, the result register holds; the input register
// keeps taking requests that give no result, and stalls once a request with
// a result waits behind the held one.
// ----------------------------------------------------------------------------
module variable_width_bit_packer_core
  import vwbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  vwbp_in_if.sink    in_chan,
  vwbp_out_if.source out_chan
);

  stage_req_t stage;
  logic       take;
  logic       out_free;
  logic       res_valid;
  result_t    res;

  vwbp_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .take    (take),
    .stage   (stage)
  );

  vwbp_pack_unit u_pack_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .out_free  (out_free),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  vwbp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_chan  (out_chan)
  );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the variable-width bit packer core.
//
// Requests go in through the request channel and results come back on the
// result channel. A scoreboard keeps its own holder, free count and byte
// count, works out the result of every accepted request and compares it
// field by field with what comes out. A short directed run covers the edge
// cases. Four random phases follow, with and without sender gaps and
// receiver stalls. Each random phase is mostly well-formed streams, with some
// noise mixed in.
// ----------------------------------------------------------------------------
module tb_top;
  import vwbp_pkg::*;

  class packer_checker;
    logic [31:0]        holder;
    logic [FBITS_W-1:0] free_cnt;
    logic [COUNT_W-1:0] byte_cnt;
    result_t            pending_words[$];
    int unsigned        mismatches;

    function new();
      holder     = '0;
      free_cnt   = FULL_FREE;
      byte_cnt   = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    function logic [63:0] low_mask(logic [FBITS_W-1:0] n);
      return (64'd1 << n) - 64'd1;
    endfunction

    function void add_word();
      logic [COUNT_W:0] next;
      next     = {1'b0, byte_cnt} + WORD_INCR;
      byte_cnt = (next > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : next[COUNT_W-1:0];
    endfunction

    // returns 1 when the request produces a result
    function bit pack_request(item_t it, output result_t res);
      logic [FBITS_W-1:0] nbits;
      logic [FBITS_W-1:0] take;
      logic [FBITS_W-1:0] used;
      logic [63:0]        val;
      logic [63:0]        shifted;
      res = '0;
      if (free_cnt < 1 || free_cnt > FULL_FREE) free_cnt = FULL_FREE;
      case (it.req_type)
        REQ_WRITE: begin
          nbits = (it.field_bits > FULL_FREE) ? FULL_FREE : it.field_bits;
          if (nbits == 0) return 1'b0;
          val      = {32'd0, it.field_value} & low_mask(nbits);
          used     = FULL_FREE - free_cnt;
          take     = (nbits < free_cnt) ? nbits : free_cnt;
          shifted  = (val & low_mask(take)) << used;
          holder   = holder | shifted[31:0];
          free_cnt = free_cnt - take;
          if (free_cnt != 0) return 1'b0;
          res.packed_word = holder;
          res.word_valid  = 1'b1;
          add_word();
          res.bytes_total = byte_cnt;
          shifted  = val >> take;
          holder   = shifted[31:0];
          free_cnt = FULL_FREE - (nbits - take);
          return 1'b1;
        end
        REQ_ALIGN: begin
          if (free_cnt >= FULL_FREE) return 1'b0;
          res.packed_word = holder;
          res.word_valid  = 1'b1;
          add_word();
          res.bytes_total = byte_cnt;
          holder   = '0;
          free_cnt = FULL_FREE;
          return 1'b1;
        end
        REQ_CLOSE: begin
          if (free_cnt < FULL_FREE) begin
            res.packed_word = holder;
            res.word_valid  = 1'b1;
            add_word();
          end
          res.bytes_total = byte_cnt;
          res.stream_end  = 1'b1;
          holder   = '0;
          free_cnt = FULL_FREE;
          byte_cnt = '0;
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void note_request(item_t it);
      result_t res;
      if (pack_request(it, res)) pending_words.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending_words.size() == 0) begin
        $error("unexpected result: packed_word %h, bytes_total %0d, stream_end %0b",
               got.packed_word, got.bytes_total, got.stream_end);
        mismatches++;
        return;
      end
      exp = pending_words.pop_front();
      if (got.packed_word !== exp.packed_word) begin
        $error("packed_word: expected %h, got %h", exp.packed_word, got.packed_word);
        mismatches++;
      end
      if (got.word_valid !== exp.word_valid) begin
        $error("word_valid: expected %0b, got %0b", exp.word_valid, got.word_valid);
        mismatches++;
      end
      if (got.bytes_total !== exp.bytes_total) begin
        $error("bytes_total: expected %0d, got %0d", exp.bytes_total, got.bytes_total);
        mismatches++;
      end
      if (got.stream_end !== exp.stream_end) begin
        $error("stream_end: expected %0b, got %0b", exp.stream_end, got.stream_end);
        mismatches++;
      end
    endfunction
  endclass

  localparam int PHASE_ITEMS = 320;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic  req_valid  = 1'b0;
  item_t req_item   = '0;
  logic  sink_ready = 1'b0;

  int idle_pct  = 0;
  int stall_pct = 0;

  packer_checker sb = new();

  vwbp_in_if  in_chan ();
  vwbp_out_if out_chan ();

  assign in_chan.valid       = req_valid;
  assign in_chan.req_type    = req_item.req_type;
  assign in_chan.field_value = req_item.field_value;
  assign in_chan.field_bits  = req_item.field_bits;
  assign out_chan.ready      = sink_ready;

  variable_width_bit_packer_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    sink_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        sb.note_request(req_item);
      end
      if (out_chan.valid && out_chan.ready) begin
        sb.check_result({out_chan.packed_word, out_chan.word_valid,
                         out_chan.bytes_total, out_chan.stream_end});
      end
    end
  end

  function automatic item_t mk_req(logic [1:0] kind, logic [31:0] value,
                                   logic [FBITS_W-1:0] nbits);
    item_t it;
    it.req_type    = kind;
    it.field_value = value;
    it.field_bits  = nbits;
    return it;
  endfunction

  // mostly writes of random width, now and then align/close, plus some noise
  function automatic item_t rand_request();
    int          pick;
    int          wsel;
    logic [31:0] value;
    pick  = $urandom_range(99);
    wsel  = $urandom_range(99);
    value = $urandom;
    if (pick < 80) begin
      if (wsel < 15)      return mk_req(REQ_WRITE, value, 6'd32);
      else if (wsel < 25) return mk_req(REQ_WRITE, value, 6'd31);
      else if (wsel < 35) return mk_req(REQ_WRITE, value, 6'(1 + $urandom_range(1)));
      else if (wsel < 40) return mk_req(REQ_WRITE, value, 6'(33 + $urandom_range(30)));
      else                return mk_req(REQ_WRITE, value, 6'(1 + $urandom_range(31)));
    end
    else if (pick < 88) return mk_req(REQ_ALIGN, value, 6'($urandom_range(63)));
    else if (pick < 94) return mk_req(REQ_CLOSE, value, 6'($urandom_range(63)));
    else if (pick < 97) return mk_req(2'd3, value, 6'($urandom_range(63)));
    else                return mk_req(REQ_WRITE, value, 6'd0);
  endfunction

  task automatic send_request(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      req_valid = 1'b0;
      req_item  = rand_request();
      @(negedge clk);
    end
    req_item  = it;
    req_valid = 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    item_t directed[$];
    int    ph;
    int    i;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed.push_back(mk_req(REQ_WRITE, 32'hFFFF_FFFF, 6'd32)); // full word at once
    directed.push_back(mk_req(REQ_WRITE, 32'hFFFF_FFFF, 6'd0));  // empty write
    directed.push_back(mk_req(REQ_ALIGN, 32'h0, 6'd0));          // align, nothing held
    directed.push_back(mk_req(REQ_CLOSE, 32'h0, 6'd0));          // close with no flush
    directed.push_back(mk_req(REQ_CLOSE, 32'hFFFF_FFFF, 6'd63)); // close on empty stream
    directed.push_back(mk_req(REQ_WRITE, 32'hFFFF_FFFE, 6'd1));  // high bits dropped
    directed.push_back(mk_req(REQ_WRITE, 32'hFFFF_FFFF, 6'd5));
    directed.push_back(mk_req(REQ_ALIGN, 32'hFFFF_FFFF, 6'd63)); // partial flush
    directed.push_back(mk_req(REQ_WRITE, 32'h7FFF_FFFF, 6'd31));
    directed.push_back(mk_req(REQ_WRITE, 32'hA5A5_A5A5, 6'd33)); // width saturates, spans
    directed.push_back(mk_req(REQ_WRITE, 32'h1234_5678, 6'd63));
    directed.push_back(mk_req(2'd3, 32'hFFFF_FFFF, 6'd32));      // unknown code dropped
    directed.push_back(mk_req(REQ_WRITE, 32'h0000_0005, 6'd3));
    directed.push_back(mk_req(REQ_CLOSE, 32'h0, 6'd0));          // close with flush
    directed.push_back(mk_req(REQ_WRITE, 32'h0, 6'd32));
    directed.push_back(mk_req(REQ_WRITE, 32'h5555_5555, 6'd32));
    directed.push_back(mk_req(REQ_WRITE, 32'hAAAA_AAAA, 6'd32));
    directed.push_back(mk_req(REQ_WRITE, 32'hFFFF_FFFF, 6'd16));
    directed.push_back(mk_req(REQ_WRITE, 32'h0001_FFFF, 6'd17)); // crosses a word, one bit left over
    directed.push_back(mk_req(REQ_ALIGN, 32'h0, 6'd0));
    directed.push_back(mk_req(REQ_CLOSE, 32'h0, 6'd0));
    foreach (directed[k]) send_request(directed[k]);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      // let everything in flight come out before the stall phase starts
      if (ph == 2) drain_results();
      for (i = 0; i < PHASE_ITEMS; i++) send_request(rand_request());
    end

    idle_pct  = 0;
    stall_pct = 0;
    drain_results();
    repeat (10) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** variable_width_bit_packer_core: PASSED **");
    end else begin
      $display("** variable_width_bit_packer_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** variable_width_bit_packer_core: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
sv/vwbp_pkg.sv
sv/vwbp_in_if.sv
sv/vwbp_out_if.sv
sv/vwbp_in_stage.sv
sv/vwbp_pack_unit.sv
sv/vwbp_out_stage.sv
sv/variable_width_bit_packer_core.sv
verif/tb_top.sv
